### src/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg: shared constants and types for the access block splitter
// Geometry of the split, field widths and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package abs_pkg;

   // split geometry
   localparam int BLOCK_BYTES      = 64;
   localparam int MAX_ACCESS_BYTES = 64;
   localparam int RESULT_LIMIT     = 11;

   // field widths
   localparam int THREAD_W = 8;
   localparam int ADDR_W   = 64;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = 4;

   // derived widths
   localparam int OFFSET_W = $clog2(BLOCK_BYTES);
   localparam int ROOM_W   = OFFSET_W + 1;
   localparam int SEG_W    = (ROOM_W > COUNT_W) ? ROOM_W : COUNT_W;
   localparam int CHUNK_W  = $clog2(RESULT_LIMIT);

   // stream packing
   localparam int REQ_DATA_W = ((THREAD_W + ADDR_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((THREAD_W + ADDR_W + SIZE_W + 7) / 8) * 8;

   // chunk size codes
   localparam logic [SIZE_W-1:0] SIZE_1 = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] SIZE_2 = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_4 = SIZE_W'(4);
   localparam logic [SIZE_W-1:0] SIZE_8 = SIZE_W'(8);

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } abs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic load_empty;
   } abs_status_type;

endpackage

### src/abs_datapath.sv
// ----------------------------------------------------------------------------
// abs_datapath: cursor, remaining count and chunk sizing
// Holds the access being split and derives the current chunk from the
// cursor offset within its block and the bytes still left.
// ----------------------------------------------------------------------------
module abs_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  abs_pkg::abs_cmd_type           cmd,
   output abs_pkg::abs_status_type        status,
   input  logic [abs_pkg::THREAD_W-1:0]   req_thread_id,
   input  logic [abs_pkg::ADDR_W-1:0]     req_start_address,
   input  logic [abs_pkg::COUNT_W-1:0]    req_byte_count,
   output logic [abs_pkg::THREAD_W-1:0]   chunk_thread,
   output logic [abs_pkg::ADDR_W-1:0]     chunk_address,
   output logic [abs_pkg::SIZE_W-1:0]     chunk_size
);
   import abs_pkg::*;

   logic [THREAD_W-1:0] thread_ff, thread_in;
   logic [ADDR_W-1:0]   cursor_ff, cursor_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [CHUNK_W-1:0]  chunks_ff, chunks_in;

   logic [COUNT_W-1:0]  count_sat;
   logic [ROOM_W-1:0]   room;
   logic [SEG_W-1:0]    seg;
   logic [SIZE_W-1:0]   size;

   // saturate the requested length
   assign count_sat = (req_byte_count > COUNT_W'(MAX_ACCESS_BYTES))
                      ? COUNT_W'(MAX_ACCESS_BYTES) : req_byte_count;

   // bytes up to the next block boundary, then the segment length
   always_comb begin
      room = ROOM_W'(BLOCK_BYTES) - ROOM_W'(cursor_ff[OFFSET_W-1:0]);
      seg  = (SEG_W'(left_ff) < SEG_W'(room)) ? SEG_W'(left_ff) : SEG_W'(room);
      if (seg >= SEG_W'(8)) begin
         size = SIZE_8;
      end else if (seg >= SEG_W'(4)) begin
         size = SIZE_4;
      end else if (seg >= SEG_W'(2)) begin
         size = SIZE_2;
      end else begin
         size = SIZE_1;
      end
   end

   // status to the controller
   assign status.last       = (left_ff == COUNT_W'(size)) ||
                              (chunks_ff == CHUNK_W'(RESULT_LIMIT - 1));
   assign status.load_empty = (req_byte_count == '0);

   // next values: a new access wins over stepping the old one
   always_comb begin
      thread_in = thread_ff;
      cursor_in = cursor_ff;
      left_in   = left_ff;
      chunks_in = chunks_ff;
      if (cmd.load) begin
         thread_in = req_thread_id;
         cursor_in = req_start_address;
         left_in   = count_sat;
         chunks_in = '0;
      end else if (cmd.advance) begin
         cursor_in = cursor_ff + ADDR_W'(size);
         left_in   = left_ff - COUNT_W'(size);
         chunks_in = chunks_ff + CHUNK_W'(1);
      end
   end

   // control counters are reset; payload is not
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         chunks_ff <= '0;
      end else begin
         left_ff   <= left_in;
         chunks_ff <= chunks_in;
      end
   end

   always_ff @(posedge clock) begin
      thread_ff <= thread_in;
      cursor_ff <= cursor_in;
   end

   assign chunk_thread  = thread_ff;
   assign chunk_address = cursor_ff;
   assign chunk_size    = size;

endmodule

### src/abs_controller.sv
// ----------------------------------------------------------------------------
// abs_controller: handshake sequencer for the access block splitter
// Idles until an access comes, then offers one chunk per ready cycle until the
// datapath flags the last one. A new access may load on the last transfer.
// ----------------------------------------------------------------------------
module abs_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  abs_pkg::abs_status_type  status,
   output abs_pkg::abs_cmd_type     cmd
);
   import abs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      req_xfer;
   logic      rsp_xfer;

   // handshakes
   assign rsp_tvalid = (state_ff == ST_RUN);
   assign req_tready = (state_ff == ST_IDLE) || (rsp_tready && status.last);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // commands
   assign cmd.load    = req_xfer;
   assign cmd.advance = rsp_xfer;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !status.load_empty) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (req_xfer) begin
               state_in = status.load_empty ? ST_IDLE : ST_RUN;
            end else if (rsp_xfer && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/access_block_splitter_top.sv
// ----------------------------------------------------------------------------
// access_block_splitter_top: splits accesses at 64-byte block boundaries
// The first chunk is offered the cycle after the access transfer.
// Throughput: one chunk per cycle from the cursor adder while rsp_tready is
//   high, and the next access loads on the last chunk.
// A zero-length access gives no chunk.
// Reset: synchronous, clears the controller and counters to idle.
// ----------------------------------------------------------------------------
module access_block_splitter_top (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: thread_id[7:0], start_address[71:8], byte_count[78:72], pad
   input  logic [abs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rsp_tdata: chunk_thread[7:0], chunk_address[71:8], chunk_size[75:72], pad
   output logic [abs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import abs_pkg::*;

   localparam int ADDR_LO  = THREAD_W;
   localparam int COUNT_LO = THREAD_W + ADDR_W;
   localparam int RSP_USED = THREAD_W + ADDR_W + SIZE_W;

   abs_cmd_type    cmd;
   abs_status_type status;
   logic [THREAD_W-1:0] chunk_thread;
   logic [ADDR_W-1:0]   chunk_address;
   logic [SIZE_W-1:0]   chunk_size;

   abs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   abs_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_thread_id     (req_tdata[THREAD_W-1:0]),
      .req_start_address (req_tdata[COUNT_LO-1:ADDR_LO]),
      .req_byte_count    (req_tdata[COUNT_LO+COUNT_W-1:COUNT_LO]),
      .chunk_thread      (chunk_thread),
      .chunk_address     (chunk_address),
      .chunk_size        (chunk_size)
   );

   // pack the result
   assign rsp_tdata = {{(RSP_DATA_W-RSP_USED){1'b0}}, chunk_size, chunk_address, chunk_thread};
   assign rsp_tlast = status.last;

   // more chunks follow a non-final transfer
   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast && !req_tready |=> rsp_tvalid)
      else $error("chunk stream stopped before last chunk");

   // consecutive chunks of one access are contiguous
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         chunk_address == $past(chunk_address) + ADDR_W'($past(chunk_size)))
      else $error("chunk address not contiguous");

   // a chunk never crosses a block boundary and has a legal size
   a_in_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((ROOM_W'(chunk_address[OFFSET_W-1:0]) + ROOM_W'(chunk_size))
                      <= ROOM_W'(BLOCK_BYTES)) &&
                     (chunk_size == SIZE_1 || chunk_size == SIZE_2 ||
                      chunk_size == SIZE_4 || chunk_size == SIZE_8))
      else $error("chunk crosses block boundary or bad size");

   // a zero-length access gives no chunk
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[COUNT_LO+COUNT_W-1:COUNT_LO] == '0)
      |=> !rsp_tvalid)
      else $error("chunk emitted for zero-length access");

endmodule
